### hw/rtl/hltp_pkg.sv
// Shared types and constants for the two-point Hough line block.
// Holds the fixed-point formats, the CORDIC angle table and the pipeline control struct.
// No dependencies.
`default_nettype none

package hltp_pkg;

  localparam int PRESCALE = 20;
  localparam int ANG_Q    = 30;
  localparam int KINV_Q   = 24;
  localparam int KINV_W   = 24;
  localparam logic [KINV_W-1:0] KINV = 24'd10188014;

  localparam int Z_W     = 34;
  localparam int ANGLE_W = 16;
  localparam int DIST_W  = 18;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30      = 64'sd3373259426;

  typedef struct packed {
    logic valid;
    logic horiz;
    logic pos;
    logic same;
  } hltp_ctl_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      0:       val = 34'sd843314857;
      1:       val = 34'sd497837829;
      2:       val = 34'sd263043837;
      3:       val = 34'sd133525159;
      4:       val = 34'sd67021687;
      5:       val = 34'sd33543516;
      6:       val = 34'sd16775851;
      7:       val = 34'sd8388437;
      8:       val = 34'sd4194283;
      9:       val = 34'sd2097149;
      default: val = (idx > ANG_Q) ? '0 : Z_W'(64'd1 << (ANG_Q - idx));
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/hltp_prep.sv
// Input stage: point differences, prescale and the quarter-turn pre-rotation.
// Uses hltp_pkg.
`default_nettype none

module hltp_prep #(
  parameter int CB = 12,
  parameter int FW = 35
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               en,
  input  wire                               in_valid,
  input  wire        [CB-1:0]               first_x,
  input  wire        [CB-1:0]               first_y,
  input  wire        [CB-1:0]               second_x,
  input  wire        [CB-1:0]               second_y,
  output hltp_pkg::hltp_ctl_t               ctl,
  output logic signed [FW-1:0]              vx,
  output logic signed [FW-1:0]              vy,
  output logic signed [FW-1:0]              px,
  output logic signed [FW-1:0]              py,
  output logic signed [hltp_pkg::Z_W-1:0]   z,
  output logic       [CB-1:0]               x1
);

  localparam int PS = hltp_pkg::PRESCALE;

  logic signed [CB:0]   u_d;
  logic signed [CB:0]   w_d;
  logic signed [FW-1:0] u_f;
  logic signed [FW-1:0] w_f;
  logic signed [FW-1:0] px1_f;
  logic signed [FW-1:0] py1_f;
  logic                 w_pos;
  hltp_pkg::hltp_ctl_t  ctl_next;

  always_comb begin
    u_d   = $signed({1'b0, second_y}) - $signed({1'b0, first_y});
    w_d   = $signed({1'b0, first_x}) - $signed({1'b0, second_x});
    u_f   = {{(FW-CB-1-PS){u_d[CB]}}, u_d, {PS{1'b0}}};
    w_f   = {{(FW-CB-1-PS){w_d[CB]}}, w_d, {PS{1'b0}}};
    px1_f = {{(FW-CB-PS){1'b0}}, first_x, {PS{1'b0}}};
    py1_f = {{(FW-CB-PS){1'b0}}, first_y, {PS{1'b0}}};
    w_pos = !w_d[CB];
    ctl_next.valid = in_valid;
    ctl_next.horiz = (w_d == '0);
    ctl_next.pos   = !u_d[CB] && (u_d != '0);
    ctl_next.same  = (w_d == '0) && (u_d == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx <= w_pos ? w_f : -w_f;
      vy <= w_pos ? -u_f : u_f;
      px <= w_pos ? py1_f : -py1_f;
      py <= w_pos ? -px1_f : px1_f;
      z  <= w_pos ? hltp_pkg::Z_W'(hltp_pkg::HALF_PI_Q30)
                  : -hltp_pkg::Z_W'(hltp_pkg::HALF_PI_Q30);
      x1 <= first_x;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hltp_cordic_stage.sv
// One registered CORDIC vectoring micro-rotation, with the point rotated alongside.
// Uses hltp_pkg for the angle table and control struct.
`default_nettype none

module hltp_cordic_stage #(
  parameter int CB    = 12,
  parameter int FW    = 35,
  parameter int STAGE = 0
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               en,
  input  wire hltp_pkg::hltp_ctl_t          ctl_in,
  input  wire signed [FW-1:0]               vx_in,
  input  wire signed [FW-1:0]               vy_in,
  input  wire signed [FW-1:0]               px_in,
  input  wire signed [FW-1:0]               py_in,
  input  wire signed [hltp_pkg::Z_W-1:0]    z_in,
  input  wire        [CB-1:0]               x1_in,
  output hltp_pkg::hltp_ctl_t               ctl,
  output logic signed [FW-1:0]              vx,
  output logic signed [FW-1:0]              vy,
  output logic signed [FW-1:0]              px,
  output logic signed [FW-1:0]              py,
  output logic signed [hltp_pkg::Z_W-1:0]   z,
  output logic       [CB-1:0]               x1
);

  localparam logic signed [hltp_pkg::Z_W-1:0] ATAN = hltp_pkg::atan_q30(STAGE);

  logic                 d_plus;
  logic signed [FW-1:0] dvx;
  logic signed [FW-1:0] dvy;
  logic signed [FW-1:0] dpx;
  logic signed [FW-1:0] dpy;

  always_comb begin
    d_plus = (vy_in > 0);
    dvx    = vy_in >>> STAGE;
    dvy    = vx_in >>> STAGE;
    dpx    = py_in >>> STAGE;
    dpy    = px_in >>> STAGE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx <= d_plus ? vx_in + dvx : vx_in - dvx;
      vy <= d_plus ? vy_in - dvy : vy_in + dvy;
      px <= d_plus ? px_in + dpx : px_in - dpx;
      py <= d_plus ? py_in - dpy : py_in + dpy;
      z  <= d_plus ? z_in + ATAN : z_in - ATAN;
      x1 <= x1_in;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hltp_post.sv
// Two output stages: gain-correction partial products and angle rounding, then
// product sum, rounding, special-case selection and saturation. Uses hltp_pkg.
`default_nettype none

module hltp_post #(
  parameter int CB  = 12,
  parameter int FW  = 35,
  parameter int AFB = 13,
  parameter int DFB = 4
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   en,
  input  wire hltp_pkg::hltp_ctl_t              ctl_in,
  input  wire signed [FW-1:0]                   px_in,
  input  wire signed [hltp_pkg::Z_W-1:0]        z_in,
  input  wire        [CB-1:0]                   x1_in,
  output hltp_pkg::hltp_ctl_t                   ctl,
  output logic signed [hltp_pkg::ANGLE_W-1:0]   line_angle,
  output logic signed [hltp_pkg::DIST_W-1:0]    line_distance,
  output logic                                  same_point
);

  localparam int ZW   = hltp_pkg::Z_W;
  localparam int PS   = hltp_pkg::PRESCALE;
  localparam int KW   = hltp_pkg::KINV_W;
  localparam int SA   = hltp_pkg::ANG_Q - AFB;
  localparam int SD   = PS + hltp_pkg::KINV_Q - DFB;
  localparam int HI_W = FW - PS;
  localparam int PW   = FW + KW + 1;

  localparam longint HALF_A = 64'sd1 <<< (SA - 1);
  localparam longint HALF_D = 64'sd1 <<< (SD - 1);
  localparam longint PI_QL  = (hltp_pkg::PI_Q30 + HALF_A) >>> SA;

  localparam logic signed [ZW-1:0] PI_Q  = ZW'(PI_QL);
  localparam logic signed [ZW-1:0] A_HI  = ZW'(2 ** (hltp_pkg::ANGLE_W - 1) - 1);
  localparam logic signed [ZW-1:0] A_LO  = -A_HI - ZW'(1);
  localparam logic signed [PW-1:0] D_HI  = PW'(2 ** (hltp_pkg::DIST_W - 1) - 1);
  localparam logic signed [PW-1:0] D_LO  = -D_HI - PW'(1);

  // stage A
  logic signed [ZW-1:0]         z_b;
  logic signed [ZW-1:0]         z_r;
  logic signed [ZW-1:0]         z_c;
  logic        [PS+KW-1:0]      pl_next;
  logic signed [HI_W+KW:0]      ph_next;
  hltp_pkg::hltp_ctl_t          ctl_a;
  logic        [PS+KW-1:0]      pl;
  logic signed [HI_W+KW:0]      ph;
  logic signed [ZW-1:0]         ang_a;
  logic        [CB-1:0]         x1_a;

  // stage B
  logic signed [PW-1:0]         v_b;
  logic signed [PW-1:0]         r_d;
  logic signed [PW-1:0]         base;
  logic signed [PW-1:0]         dist_pre;
  logic signed [ZW-1:0]         ang_pre;
  logic signed [ZW-1:0]         ang_sat;
  logic signed [PW-1:0]         dist_sat;

  always_comb begin
    // round half away from zero: add half, less one when negative, then floor
    z_b = z_in + ZW'(HALF_A) - ZW'(z_in[ZW-1]);
    z_r = z_b >>> SA;
    if (z_r > PI_Q) begin
      z_c = PI_Q;
    end else if (z_r < -PI_Q) begin
      z_c = -PI_Q;
    end else begin
      z_c = z_r;
    end
    pl_next = px_in[PS-1:0] * hltp_pkg::KINV;
    ph_next = $signed(px_in[FW-1:PS]) * $signed({1'b0, hltp_pkg::KINV});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else if (en) begin
      ctl_a <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl    <= pl_next;
      ph    <= ph_next;
      ang_a <= z_c;
      x1_a  <= x1_in;
    end
  end

  always_comb begin
    v_b  = (PW'(ph) <<< PS) + PW'(pl) + PW'(HALF_D) - PW'(ph[HI_W+KW]);
    r_d  = v_b >>> SD;
    base = PW'(x1_a) <<< DFB;
    if (ctl_a.horiz) begin
      dist_pre = ctl_a.pos ? base : -base;
      ang_pre  = ctl_a.pos ? '0 : PI_Q;
    end else begin
      dist_pre = r_d;
      ang_pre  = ang_a;
    end
    if (dist_pre > D_HI) begin
      dist_sat = D_HI;
    end else if (dist_pre < D_LO) begin
      dist_sat = D_LO;
    end else begin
      dist_sat = dist_pre;
    end
    if (ang_pre > A_HI) begin
      ang_sat = A_HI;
    end else if (ang_pre < A_LO) begin
      ang_sat = A_LO;
    end else begin
      ang_sat = ang_pre;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line_angle    <= ang_sat[hltp_pkg::ANGLE_W-1:0];
      line_distance <= dist_sat[hltp_pkg::DIST_W-1:0];
      same_point    <= ctl_a.same;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hltp_out_buf.sv
// Output register with a skid entry; its full flag freezes the pipeline.
// Uses hltp_pkg for the result widths.
`default_nettype none

module hltp_out_buf (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   push,
  input  wire signed [hltp_pkg::ANGLE_W-1:0]    push_angle,
  input  wire signed [hltp_pkg::DIST_W-1:0]     push_distance,
  input  wire                                   push_same,
  output logic                                  full,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [hltp_pkg::ANGLE_W-1:0]   line_angle,
  output logic signed [hltp_pkg::DIST_W-1:0]    line_distance,
  output logic                                  same_point
);

  logic signed [hltp_pkg::ANGLE_W-1:0] skid_angle;
  logic signed [hltp_pkg::DIST_W-1:0]  skid_distance;
  logic                                skid_same;
  logic                                out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      full      <= 1'b0;
    end else if (out_free) begin
      if (full) begin
        out_valid <= 1'b1;
        full      <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (full) begin
        line_angle    <= skid_angle;
        line_distance <= skid_distance;
        same_point    <= skid_same;
      end else if (push) begin
        line_angle    <= push_angle;
        line_distance <= push_distance;
        same_point    <= push_same;
      end
    end else if (push) begin
      skid_angle    <= push_angle;
      skid_distance <= push_distance;
      skid_same     <= push_same;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hough_line_from_two_points.sv
// Top level: Hough normal-form line (theta, rho) through two image points.
// Instantiates hltp_prep, hltp_cordic_stage, hltp_post, hltp_out_buf; uses hltp_pkg.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------
//   input   | in_valid  | in_stall  | first_x, first_y, second_x, second_y
//   output  | out_valid | out_stall | line_angle, line_distance, same_point
//
// One point pair per cycle while in_stall is low; registers in order: input stage,
// one register per CORDIC micro-rotation, two output stages, output register.
// rst clears every valid bit; data registers are not reset.
// A stalled output fills the skid entry, which then freezes the whole pipeline
// and raises in_stall until the entry drains.
`default_nettype none

module hough_line_from_two_points #(
  parameter int COORD_BITS      = 12,
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int DIST_FRAC_BITS  = 4
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire        [COORD_BITS-1:0]           first_x,
  input  wire        [COORD_BITS-1:0]           first_y,
  input  wire        [COORD_BITS-1:0]           second_x,
  input  wire        [COORD_BITS-1:0]           second_y,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [hltp_pkg::ANGLE_W-1:0]   line_angle,
  output logic signed [hltp_pkg::DIST_W-1:0]    line_distance,
  output logic                                  same_point
);

  localparam int CB = COORD_BITS;
  localparam int FW = COORD_BITS + hltp_pkg::PRESCALE + 3;
  localparam int N  = CORDIC_STAGES;

  logic                                 en;
  logic                                 full;
  logic                                 push;

  hltp_pkg::hltp_ctl_t                  ctl_c [N+1];
  logic signed [FW-1:0]                 vx_c  [N+1];
  logic signed [FW-1:0]                 vy_c  [N+1];
  logic signed [FW-1:0]                 px_c  [N+1];
  logic signed [FW-1:0]                 py_c  [N+1];
  logic signed [hltp_pkg::Z_W-1:0]      z_c   [N+1];
  logic        [CB-1:0]                 x1_c  [N+1];

  hltp_pkg::hltp_ctl_t                  post_ctl;
  logic signed [hltp_pkg::ANGLE_W-1:0]  post_angle;
  logic signed [hltp_pkg::DIST_W-1:0]   post_distance;
  logic                                 post_same;

  assign en       = !full;
  assign in_stall = full;
  assign push     = post_ctl.valid && en;

  hltp_prep #(.CB(CB), .FW(FW)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .first_x  (first_x),
    .first_y  (first_y),
    .second_x (second_x),
    .second_y (second_y),
    .ctl      (ctl_c[0]),
    .vx       (vx_c[0]),
    .vy       (vy_c[0]),
    .px       (px_c[0]),
    .py       (py_c[0]),
    .z        (z_c[0]),
    .x1       (x1_c[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_stage
    hltp_cordic_stage #(.CB(CB), .FW(FW), .STAGE(i)) u_stage (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctl_in (ctl_c[i]),
      .vx_in  (vx_c[i]),
      .vy_in  (vy_c[i]),
      .px_in  (px_c[i]),
      .py_in  (py_c[i]),
      .z_in   (z_c[i]),
      .x1_in  (x1_c[i]),
      .ctl    (ctl_c[i+1]),
      .vx     (vx_c[i+1]),
      .vy     (vy_c[i+1]),
      .px     (px_c[i+1]),
      .py     (py_c[i+1]),
      .z      (z_c[i+1]),
      .x1     (x1_c[i+1])
    );
  end

  hltp_post #(
    .CB  (CB),
    .FW  (FW),
    .AFB (ANGLE_FRAC_BITS),
    .DFB (DIST_FRAC_BITS)
  ) u_post (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .ctl_in        (ctl_c[N]),
    .px_in         (px_c[N]),
    .z_in          (z_c[N]),
    .x1_in         (x1_c[N]),
    .ctl           (post_ctl),
    .line_angle    (post_angle),
    .line_distance (post_distance),
    .same_point    (post_same)
  );

  hltp_out_buf u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .push_angle    (post_angle),
    .push_distance (post_distance),
    .push_same     (post_same),
    .full          (full),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .line_angle    (line_angle),
    .line_distance (line_distance),
    .same_point    (same_point)
  );

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    full |-> out_valid)
    else $error("skid entry full while output register empty");

  a_frozen_keeps_item: assert property (@(posedge clk) disable iff (rst)
    (post_ctl.valid && full) |=> post_ctl.valid)
    else $error("last pipeline item lost while frozen");

  a_same_point_angle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && same_point) |-> (line_angle > 0))
    else $error("coincident points without angle pi");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_hough_line_from_two_points.sv
// Self-checking testbench for hough_line_from_two_points: directed point pairs, then random ones.
// Behavioral CORDIC predictor: expected (theta, rho, same) of unlisted pairs under random stalls.
// Depends on hltp_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_hough_line_from_two_points;

  localparam int COORD_BITS      = 12;
  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int DIST_FRAC_BITS  = 4;
  localparam int RANDOM_PAIRS    = 1930;
  localparam int IDLE_LIMIT      = 5000;
  localparam int COORD_MAX       = (1 << COORD_BITS) - 1;

  typedef struct packed {
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
  } pair_t;

  typedef struct packed {
    logic signed [hltp_pkg::ANGLE_W-1:0] angle;
    logic signed [hltp_pkg::DIST_W-1:0]  distance;
    logic                                same;
  } line_t;

  typedef struct packed {
    pair_t pair;
    logic  known;
    line_t result;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [COORD_BITS-1:0] first_x = '0;
  logic [COORD_BITS-1:0] first_y = '0;
  logic [COORD_BITS-1:0] second_x = '0;
  logic [COORD_BITS-1:0] second_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [hltp_pkg::ANGLE_W-1:0] line_angle;
  logic signed [hltp_pkg::DIST_W-1:0]  line_distance;
  logic same_point;

  line_t    expected_lines[$];
  dir_row_t dir_rows[$];
  int       error_count = 0;
  int       idle_cycles = 0;
  int       stall_left = 0;
  bit       calm = 1'b0;
  line_t    want;

  hough_line_from_two_points #(
    .COORD_BITS(COORD_BITS),
    .CORDIC_STAGES(CORDIC_STAGES),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .DIST_FRAC_BITS(DIST_FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .first_x(first_x),
    .first_y(first_y),
    .second_x(second_x),
    .second_y(second_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .line_angle(line_angle),
    .line_distance(line_distance),
    .same_point(same_point)
  );

  always #2 clk = ~clk;

  function automatic longint micro_angle(input int i);
    longint small_angles[10];
    small_angles = '{64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
                     64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
                     64'sd4194283, 64'sd2097149};
    if (i < 10) return small_angles[i];
    if (i > hltp_pkg::ANG_Q) return 0;
    return 64'sd1 <<< (hltp_pkg::ANG_Q - i);
  endfunction

  // round to nearest, ties away from zero
  function automatic longint round_away(input longint v, input int s);
    longint half;
    if (s <= 0) return v;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint clip(input longint v, input int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic line_t predict_line(input pair_t p);
    longint u, w, vx, vy, px, py, z, t, dvx, dvy, dpx, dpy, ang, rho, pi_q;
    line_t res;
    u = longint'(p.by) - longint'(p.ay);
    w = longint'(p.ax) - longint'(p.bx);
    pi_q = round_away(hltp_pkg::PI_Q30, hltp_pkg::ANG_Q - ANGLE_FRAC_BITS);
    res.same = 1'b0;
    if (w == 0) begin
      rho = longint'(p.ax) * (64'sd1 <<< DIST_FRAC_BITS);
      if (u > 0) begin
        ang = 0;
      end else begin
        ang = pi_q;
        rho = -rho;
        res.same = (u == 0);
      end
    end else begin
      u = u * (64'sd1 <<< hltp_pkg::PRESCALE);
      w = w * (64'sd1 <<< hltp_pkg::PRESCALE);
      px = longint'(p.ax) * (64'sd1 <<< hltp_pkg::PRESCALE);
      py = longint'(p.ay) * (64'sd1 <<< hltp_pkg::PRESCALE);
      if (w >= 0) begin
        vx = w;
        vy = -u;
        t = px;
        px = py;
        py = -t;
        z = hltp_pkg::HALF_PI_Q30;
      end else begin
        vx = -w;
        vy = u;
        t = px;
        px = -py;
        py = t;
        z = -hltp_pkg::HALF_PI_Q30;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        dvx = vy >>> i;
        dvy = vx >>> i;
        dpx = py >>> i;
        dpy = px >>> i;
        if (vy > 0) begin
          vx += dvx;
          vy -= dvy;
          px += dpx;
          py -= dpy;
          z += micro_angle(i);
        end else begin
          vx -= dvx;
          vy += dvy;
          px -= dpx;
          py += dpy;
          z -= micro_angle(i);
        end
      end
      ang = round_away(z, hltp_pkg::ANG_Q - ANGLE_FRAC_BITS);
      if (ang > pi_q) ang = pi_q;
      if (ang < -pi_q) ang = -pi_q;
      rho = round_away(px * longint'(hltp_pkg::KINV),
                       hltp_pkg::PRESCALE + hltp_pkg::KINV_Q - DIST_FRAC_BITS);
    end
    res.angle = hltp_pkg::ANGLE_W'(clip(ang, hltp_pkg::ANGLE_W));
    res.distance = hltp_pkg::DIST_W'(clip(rho, hltp_pkg::DIST_W));
    return res;
  endfunction

  function automatic void add_row(input int ax, input int ay, input int bx, input int by,
                                  input bit known, input int angle, input int distance,
                                  input bit same);
    dir_row_t r;
    r.pair = '{COORD_BITS'(ax), COORD_BITS'(ay), COORD_BITS'(bx), COORD_BITS'(by)};
    r.known = known;
    r.result.angle = hltp_pkg::ANGLE_W'(angle);
    r.result.distance = hltp_pkg::DIST_W'(distance);
    r.result.same = same;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return COORD_MAX;
      default: return int'($urandom_range(0, COORD_MAX));
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int kind;
    p.ax = COORD_BITS'($urandom_range(0, COORD_MAX));
    p.ay = COORD_BITS'($urandom_range(0, COORD_MAX));
    p.bx = COORD_BITS'($urandom_range(0, COORD_MAX));
    p.by = COORD_BITS'($urandom_range(0, COORD_MAX));
    kind = int'($urandom_range(0, 99));
    if (kind < 40) begin
    end else if (kind < 50) begin
      p.bx = p.ax;
      p.by = p.ay;
    end else if (kind < 60) begin
      p.bx = p.ax;
    end else if (kind < 68) begin
      p.by = p.ay;
    end else if (kind < 85) begin
      p.bx = COORD_BITS'(clamp_coord(int'(p.ax) + int'($urandom_range(0, 6)) - 3));
      p.by = COORD_BITS'(clamp_coord(int'(p.ay) + int'($urandom_range(0, 6)) - 3));
    end else begin
      p.ax = COORD_BITS'(pick_coord());
      p.ay = COORD_BITS'(pick_coord());
      p.bx = COORD_BITS'(pick_coord());
      p.by = COORD_BITS'(pick_coord());
    end
    return p;
  endfunction

  // drive one pair from a falling edge, return at the falling edge after its transfer
  task automatic send_pair(input pair_t p, input bit known, input line_t result);
    in_valid <= 1'b1;
    first_x <= p.ax;
    first_y <= p.ay;
    second_x <= p.bx;
    second_y <= p.by;
    do @(posedge clk); while (in_stall);
    expected_lines.insert(expected_lines.size(), known ? result : predict_line(p));
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (!calm) begin
      if (r >= 92) n = $urandom_range(8, 30);
      else if (r >= 70) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_lines.size() != 0) @(negedge clk);
  endtask

  initial begin
    add_row(0, 0, 0, 0, 1, 25736, 0, 1);
    add_row(4095, 4095, 4095, 4095, 1, 25736, -65520, 1);
    add_row(4095, 0, 4095, 4095, 1, 0, 65520, 0);
    add_row(4095, 4095, 4095, 0, 1, 25736, -65520, 0);
    add_row(0, 0, 0, 4095, 1, 0, 0, 0);
    add_row(0, 4095, 0, 0, 1, 25736, 0, 0);
    add_row(1, 7, 0, 7, 0, 0, 0, 0);
    add_row(0, 7, 1, 7, 0, 0, 0, 0);
    add_row(4095, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 4095, 4095, 4095, 0, 0, 0, 0);
    add_row(0, 0, 4095, 4095, 0, 0, 0, 0);
    add_row(4095, 4095, 0, 0, 0, 0, 0, 0);
    add_row(4095, 0, 0, 4095, 0, 0, 0, 0);
    add_row(0, 4095, 4095, 0, 0, 0, 0, 0);
    add_row(1, 4095, 0, 0, 0, 0, 0, 0);
    add_row(0, 4095, 1, 0, 0, 0, 0, 0);
    add_row(4095, 4095, 4094, 0, 0, 0, 0, 0);
    add_row(4094, 4095, 4095, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 4095, 0, 0, 0, 0);
    add_row(2048, 2048, 2049, 2049, 0, 0, 0, 0);
    add_row(2730, 1365, 1365, 2730, 0, 0, 0, 0);
    add_row(3000, 17, 12, 4000, 0, 0, 0, 0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      send_pair(dir_rows[k].pair, dir_rows[k].known, dir_rows[k].result);
      sender_gap();
    end
    drain_pipeline();

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_PAIRS / 2) drain_pipeline();
      send_pair(random_pair(), 1'b0, '0);
      sender_gap();
    end
    in_valid <= 1'b0;

    while (expected_lines.size() != 0) @(posedge clk);
    repeat (CORDIC_STAGES + 12) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!calm) begin
        case ($urandom_range(0, 19))
          0, 1, 2: stall_left <= $urandom_range(1, 3);
          3:       stall_left <= $urandom_range(10, 40);
          default: stall_left <= 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_lines.size() == 0) begin
        $error("result transfer with no pending pair");
        error_count++;
      end else begin
        want = expected_lines.pop_front();
        if (line_angle !== want.angle) begin
          $error("line_angle: expected %0d, got %0d", want.angle, line_angle);
          error_count++;
        end
        if (line_distance !== want.distance) begin
          $error("line_distance: expected %0d, got %0d", want.distance, line_distance);
          error_count++;
        end
        if (same_point !== want.same) begin
          $error("same_point: expected %0d, got %0d", want.same, same_point);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
